### hdl/abbe_pkg.sv
package abbe_pkg;

  localparam int unsigned ADDR_W   = 26;
  localparam int unsigned SRC_W    = 32;
  localparam int unsigned DEST_W   = 24;
  localparam int unsigned NBYTES_W = 3;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 13;

  // blend channels and full-scale channel value
  localparam int unsigned NUM_CH = 3;
  localparam logic [7:0]  CH_MAX = 8'd255;

  localparam logic [2:0] DEPTH_MIN = 3'd1;
  localparam logic [2:0] DEPTH_MAX = 3'd4;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PARENT_WIDTH = 3'd0,
    REG_PARENT_DEPTH = 3'd1,
    REG_POS_X        = 3'd2,
    REG_POS_Y        = 3'd3,
    REG_OBJ_WIDTH    = 3'd4,
    REG_OBJ_HEIGHT   = 3'd5,
    REG_OBJ_DEPTH    = 3'd6,
    REG_BLEND_MODE   = 3'd7
  } cfg_reg_e;

  typedef enum logic {
    MODE_OPAQUE = 1'b0,
    MODE_ALPHA  = 1'b1
  } mode_e;

  function automatic logic [2:0] clamp_depth(input logic [2:0] v);
    logic [2:0] r;
    if (v < DEPTH_MIN) begin
      r = DEPTH_MIN;
    end else if (v > DEPTH_MAX) begin
      r = DEPTH_MAX;
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

### hdl/abbe_in_if.sv
interface abbe_in_if;
  logic                       valid;
  logic                       ready;
  logic [abbe_pkg::SRC_W-1:0]  src_pixel;
  logic [abbe_pkg::DEST_W-1:0] dest_pixel;

  modport source (output valid, output src_pixel, output dest_pixel, input ready);
  modport sink   (input valid, input src_pixel, input dest_pixel, output ready);
endinterface

### hdl/abbe_out_if.sv
interface abbe_out_if;
  logic                          valid;
  logic                          ready;
  logic [abbe_pkg::ADDR_W-1:0]   dest_addr;
  logic [abbe_pkg::SRC_W-1:0]    out_pixel;
  logic [abbe_pkg::NBYTES_W-1:0] write_bytes;
  logic                          last;
  logic                          error;

  modport source (output valid, output dest_addr, output out_pixel, output write_bytes,
                  output last, output error, input ready);
  modport sink   (input valid, input dest_addr, input out_pixel, input write_bytes,
                  input last, input error, output ready);
endinterface

### hdl/abbe_blend.sv
module abbe_blend (
  input  logic [abbe_pkg::SRC_W-1:0]  src_i,
  input  logic [abbe_pkg::DEST_W-1:0] dst_i,
  output logic [abbe_pkg::DEST_W-1:0] pix_o
);

  logic [7:0] alpha;
  logic [7:0] inv_alpha;

  assign alpha     = src_i[31:24];
  assign inv_alpha = abbe_pkg::CH_MAX - alpha;

  for (genvar k = 0; k < abbe_pkg::NUM_CH; k++) begin : g_lane
    logic [7:0]  s;
    logic [7:0]  d;
    logic [15:0] mix;
    logic [16:0] rnd;

    assign s   = src_i[8*k +: 8];
    assign d   = dst_i[8*k +: 8];
    assign mix = 16'(d) * 16'(inv_alpha) + 16'(s) * 16'(alpha);
    // exact floor(mix / 255) for mix up to 255 * 255
    assign rnd = 17'(mix) + 17'd1 + 17'(mix[15:8]);
    assign pix_o[8*k +: 8] = rnd[15:8];
  end

endmodule

### hdl/abbe_scan.sv
module abbe_scan #(
  parameter int unsigned MAX_DIM = 4096,
  localparam int unsigned CNT_W = $clog2(MAX_DIM)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  abbe_pkg::mode_e   mode_i,
  input  logic [CNT_W-1:0]  w_m1_i,
  input  logic [CNT_W-1:0]  h_m1_i,
  output logic [CNT_W-1:0]  col_o,
  output logic [CNT_W-1:0]  row_o,
  output logic              last_o
);

  logic [CNT_W-1:0] col_q, col_d;
  logic [CNT_W-1:0] row_q, row_d;
  logic             col_end;
  logic             row_end;

  // a counter left past the edge by a geometry change wraps when it next advances
  assign col_end = col_q >= w_m1_i;
  assign row_end = row_q >= h_m1_i;

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (mode_i == abbe_pkg::MODE_ALPHA) begin
      // column-major
      if (row_end) begin
        row_d = '0;
        col_d = col_end ? '0 : col_q + 1'b1;
      end else begin
        row_d = row_q + 1'b1;
      end
    end else begin
      if (col_end) begin
        col_d = '0;
        row_d = row_end ? '0 : row_q + 1'b1;
      end else begin
        col_d = col_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (step_i) begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  assign col_o  = col_q;
  assign row_o  = row_q;
  assign last_o = col_end && row_end;

endmodule

### hdl/alpha_blend_blit_engine_top.sv
// Blitter for one rectangular object onto a parent framebuffer. Each item
// carries one object pixel in scan order (row-major for opaque copy,
// column-major for alpha blend) and the parent pixel at that place; the block
// tracks the object column and row itself and returns one write per item:
// parent byte address, pixel bytes, byte count, a last flag on the object's
// final pixel and an error flag for alpha mode with an object depth other
// than 4. Each item passes through the input register, then the result
// register, with the address multiply and the three channel blends in the
// single logic pass between them, and one item per clock is sustained while
// the sink keeps taking results. The user must write configuration through
// the register port only while no item is in flight; the block itself does
// not enforce this. The column and row counters are left alone by
// configuration writes.
module alpha_blend_blit_engine_top #(
  parameter int unsigned MAX_DIM = 4096
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [abbe_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [abbe_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  abbe_in_if.sink                            in_item_i,
  abbe_out_if.source                         out_item_o
);

  localparam int unsigned DIM_W  = $clog2(MAX_DIM + 1);
  localparam int unsigned CNT_W  = $clog2(MAX_DIM);
  localparam int unsigned RB_W   = DIM_W + 3;
  localparam int unsigned SUM_W  = ((CNT_W > 12) ? CNT_W : 12) + 1;
  localparam int unsigned ADDR_W = abbe_pkg::ADDR_W;
  localparam int unsigned PW_RST = (MAX_DIM < 640) ? MAX_DIM : 640;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [12:0] v);
    logic [DIM_W-1:0] r;
    if (v == 13'd0) begin
      r = DIM_W'(1);
    end else if (32'(v) > MAX_DIM) begin
      r = DIM_W'(MAX_DIM);
    end else begin
      r = DIM_W'(v);
    end
    return r;
  endfunction

  // configuration, held in clamped form
  logic [DIM_W-1:0]  pw_q;
  logic [2:0]        pd_q;
  logic [11:0]       pos_x_q;
  logic [11:0]       pos_y_q;
  logic [CNT_W-1:0]  w_m1_q;
  logic [CNT_W-1:0]  h_m1_q;
  logic [2:0]        od_q;
  logic              od_is4_q;
  abbe_pkg::mode_e   mode_q;
  logic [RB_W-1:0]   row_bytes_q;

  logic [DIM_W-1:0]  pw_new;
  logic [2:0]        pd_new;

  assign pw_new = clamp_dim(cfg_data_i);
  assign pd_new = abbe_pkg::clamp_depth(cfg_data_i[2:0]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pw_q        <= DIM_W'(PW_RST);
      pd_q        <= abbe_pkg::DEPTH_MAX;
      pos_x_q     <= '0;
      pos_y_q     <= '0;
      w_m1_q      <= '0;
      h_m1_q      <= '0;
      od_q        <= abbe_pkg::DEPTH_MAX;
      od_is4_q    <= 1'b1;
      mode_q      <= abbe_pkg::MODE_OPAQUE;
      row_bytes_q <= RB_W'(PW_RST * 4);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        abbe_pkg::REG_PARENT_WIDTH: begin
          pw_q        <= pw_new;
          row_bytes_q <= RB_W'(RB_W'(pw_new) * RB_W'(pd_q));
        end
        abbe_pkg::REG_PARENT_DEPTH: begin
          pd_q        <= pd_new;
          row_bytes_q <= RB_W'(RB_W'(pw_q) * RB_W'(pd_new));
        end
        abbe_pkg::REG_POS_X:      pos_x_q <= cfg_data_i[11:0];
        abbe_pkg::REG_POS_Y:      pos_y_q <= cfg_data_i[11:0];
        abbe_pkg::REG_OBJ_WIDTH:  w_m1_q  <= CNT_W'(pw_new - DIM_W'(1));
        abbe_pkg::REG_OBJ_HEIGHT: h_m1_q  <= CNT_W'(pw_new - DIM_W'(1));
        abbe_pkg::REG_OBJ_DEPTH: begin
          od_q     <= pd_new;
          od_is4_q <= cfg_data_i[2:0] == abbe_pkg::DEPTH_MAX;
        end
        abbe_pkg::REG_BLEND_MODE: mode_q <= abbe_pkg::mode_e'(cfg_data_i[0]);
        default: ;
      endcase
    end
  end

  // handshake: input register feeds result register
  logic in_vld_q;
  logic out_vld_q;
  logic out_free;
  logic step;

  assign out_free        = !out_vld_q || out_item_o.ready;
  assign step            = in_vld_q && out_free;
  assign in_item_i.ready = !in_vld_q || out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (in_item_i.ready) begin
        in_vld_q <= in_item_i.valid;
      end
      if (out_free) begin
        out_vld_q <= in_vld_q;
      end
    end
  end

  logic [abbe_pkg::SRC_W-1:0]  src_q;
  logic [abbe_pkg::DEST_W-1:0] dst_q;

  always_ff @(posedge clk_i) begin
    if (in_item_i.ready && in_item_i.valid) begin
      src_q <= in_item_i.src_pixel;
      dst_q <= in_item_i.dest_pixel;
    end
  end

  logic [CNT_W-1:0] col;
  logic [CNT_W-1:0] row;
  logic             last;

  abbe_scan #(
    .MAX_DIM (MAX_DIM)
  ) u_scan (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .mode_i (mode_q),
    .w_m1_i (w_m1_q),
    .h_m1_i (h_m1_q),
    .col_o  (col),
    .row_o  (row),
    .last_o (last)
  );

  logic [abbe_pkg::DEST_W-1:0] blend_pix;

  abbe_blend u_blend (
    .src_i (src_q),
    .dst_i (dst_q),
    .pix_o (blend_pix)
  );

  logic [SUM_W-1:0]  x_sum;
  logic [SUM_W-1:0]  y_sum;
  logic [ADDR_W-1:0] row_off;
  logic [ADDR_W-1:0] addr_d;
  logic [abbe_pkg::SRC_W-1:0] pix_d;
  logic [abbe_pkg::NBYTES_W-1:0] nbytes_d;
  logic              err_d;

  assign x_sum   = SUM_W'(pos_x_q) + SUM_W'(col);
  assign y_sum   = SUM_W'(pos_y_q) + SUM_W'(row);
  assign row_off = ADDR_W'(ADDR_W'(row_bytes_q) * ADDR_W'(y_sum));

  always_comb begin
    addr_d   = '0;
    pix_d    = '0;
    nbytes_d = '0;
    err_d    = 1'b0;
    if (mode_q == abbe_pkg::MODE_ALPHA) begin
      if (od_is4_q) begin
        addr_d   = row_off + ADDR_W'(ADDR_W'(x_sum) * ADDR_W'(pd_q));
        pix_d    = {8'h00, blend_pix};
        nbytes_d = abbe_pkg::NBYTES_W'(abbe_pkg::NUM_CH);
      end else begin
        err_d = 1'b1;
      end
    end else begin
      addr_d   = row_off + ADDR_W'(ADDR_W'(pos_x_q) * ADDR_W'(pd_q))
               + ADDR_W'(ADDR_W'(col) * ADDR_W'(od_q));
      nbytes_d = od_q;
      case (od_q)
        3'd1:    pix_d = {24'h0, src_q[7:0]};
        3'd2:    pix_d = {16'h0, src_q[15:0]};
        3'd3:    pix_d = {8'h0, src_q[23:0]};
        default: pix_d = src_q;
      endcase
    end
  end

  logic [ADDR_W-1:0]             addr_q;
  logic [abbe_pkg::SRC_W-1:0]    pix_q;
  logic [abbe_pkg::NBYTES_W-1:0] nbytes_q;
  logic                          last_q;
  logic                          err_q;

  always_ff @(posedge clk_i) begin
    if (step) begin
      addr_q   <= addr_d;
      pix_q    <= pix_d;
      nbytes_q <= nbytes_d;
      last_q   <= last;
      err_q    <= err_d;
    end
  end

  assign out_item_o.valid       = out_vld_q;
  assign out_item_o.dest_addr   = addr_q;
  assign out_item_o.out_pixel   = pix_q;
  assign out_item_o.write_bytes = nbytes_q;
  assign out_item_o.last        = last_q;
  assign out_item_o.error       = err_q;

endmodule

### test/tb_alpha_blend_blit_engine_top.sv
module tb_alpha_blend_blit_engine_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MAX_DIM      = 4096;
  localparam int unsigned TOTAL_ITEMS  = 1525;
  localparam int unsigned IDLE_LIMIT   = 1000;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned MAX_REPORTS  = 10;

  typedef struct packed {
    logic [abbe_pkg::SRC_W-1:0]  src;
    logic [abbe_pkg::DEST_W-1:0] dest;
  } pixel_pair_t;

  typedef struct packed {
    logic [abbe_pkg::ADDR_W-1:0]   addr;
    logic [abbe_pkg::SRC_W-1:0]    pixel;
    logic [abbe_pkg::NBYTES_W-1:0] nbytes;
    logic                          last;
    logic                          err;
  } blit_write_t;

  logic                            clk = 1'b0;
  logic                            rst_n;
  logic                            cfg_we;
  abbe_pkg::cfg_reg_e              cfg_idx;
  logic [abbe_pkg::CFG_DATA_W-1:0] cfg_data;

  abbe_in_if  in_if ();
  abbe_out_if out_if ();

  logic in_fire;
  logic out_fire;
  logic in_taken = 1'b0;

  assign in_fire  = in_if.valid && in_if.ready;
  assign out_fire = out_if.valid && out_if.ready;

  // shadow of the register file and the scan position
  logic [12:0]     cfg_pw;
  logic [2:0]      cfg_pd;
  logic [11:0]     cfg_px;
  logic [11:0]     cfg_py;
  logic [12:0]     cfg_w;
  logic [12:0]     cfg_h;
  logic [2:0]      cfg_od;
  abbe_pkg::mode_e cfg_mode;
  int unsigned     col_cnt;
  int unsigned     row_cnt;

  pixel_pair_t pixel_queue[$];
  blit_write_t expected_writes[$];

  int unsigned queued = 0;
  int unsigned n_items = 0;
  int unsigned n_blends = 0;
  int unsigned n_errs = 0;
  int unsigned n_ends = 0;
  int unsigned n_setups = 0;
  int unsigned mismatches = 0;
  int unsigned idle_cycles = 0;

  int unsigned gap_left = 0;
  int unsigned burst_left = 0;
  logic [15:0] stall_pat = '1;
  logic [3:0]  pat_pos = '0;
  int unsigned pat_left = 0;

  alpha_blend_blit_engine_top #(
    .MAX_DIM(MAX_DIM)
  ) u_dut (
    .clk_i     (clk),
    .rst_ni    (rst_n),
    .cfg_we_i  (cfg_we),
    .cfg_idx_i (cfg_idx),
    .cfg_data_i(cfg_data),
    .in_item_i (in_if),
    .out_item_o(out_if)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic int unsigned fit_range(int unsigned v, int unsigned lo, int unsigned hi);
    int unsigned r;
    r = v;
    if (v < lo) r = lo;
    if (v > hi) r = hi;
    return r;
  endfunction

  // expected write for one pixel; moves the scan position like the block does
  function automatic blit_write_t predict_write(pixel_pair_t px);
    blit_write_t       wr;
    int unsigned       w, h, pw, pd, od, alpha, s, d, mix;
    longint unsigned   row_bytes, byte_addr, ox, oy, cc, rc;
    logic              col_end, row_end;
    w  = fit_range(cfg_w, 1, MAX_DIM);
    h  = fit_range(cfg_h, 1, MAX_DIM);
    pw = fit_range(cfg_pw, 1, MAX_DIM);
    pd = fit_range(cfg_pd, abbe_pkg::DEPTH_MIN, abbe_pkg::DEPTH_MAX);
    od = fit_range(cfg_od, abbe_pkg::DEPTH_MIN, abbe_pkg::DEPTH_MAX);
    row_bytes = pw * pd;
    ox = cfg_px;
    oy = cfg_py;
    cc = col_cnt;
    rc = row_cnt;
    byte_addr = 0;
    wr = '0;
    col_end = col_cnt >= w - 1;
    row_end = row_cnt >= h - 1;
    wr.last = col_end && row_end;
    if (cfg_mode == abbe_pkg::MODE_ALPHA) begin
      if (cfg_od != abbe_pkg::DEPTH_MAX) begin
        wr.err = 1'b1;
      end else begin
        alpha = px.src[31:24];
        for (int k = 0; k < abbe_pkg::NUM_CH; k++) begin
          s = px.src[8*k +: 8];
          d = px.dest[8*k +: 8];
          mix = (d * (abbe_pkg::CH_MAX - alpha) + s * alpha) / abbe_pkg::CH_MAX;
          wr.pixel[8*k +: 8] = mix[7:0];
        end
        byte_addr = (ox + cc) * pd + row_bytes * (oy + rc);
        wr.nbytes = abbe_pkg::NBYTES_W'(abbe_pkg::NUM_CH);
      end
      // column-major scan
      if (row_end) begin
        row_cnt = 0;
        col_cnt = col_end ? 0 : col_cnt + 1;
      end else begin
        row_cnt++;
      end
    end else begin
      wr.pixel = px.src & ~({abbe_pkg::SRC_W{1'b1}} << (8 * od));
      byte_addr = row_bytes * (oy + rc) + ox * pd + cc * od;
      wr.nbytes = abbe_pkg::NBYTES_W'(od);
      // row-major scan
      if (col_end) begin
        col_cnt = 0;
        row_cnt = row_end ? 0 : row_cnt + 1;
      end else begin
        col_cnt++;
      end
    end
    wr.addr = byte_addr[abbe_pkg::ADDR_W-1:0];
    return wr;
  endfunction

  function automatic logic [abbe_pkg::CFG_DATA_W-1:0] pick_value(abbe_pkg::cfg_reg_e idx);
    logic [abbe_pkg::CFG_DATA_W-1:0] v;
    int unsigned                     roll;
    roll = $urandom_range(9);
    case (idx)
      abbe_pkg::REG_PARENT_WIDTH, abbe_pkg::REG_OBJ_WIDTH, abbe_pkg::REG_OBJ_HEIGHT: begin
        if (roll < 6) begin
          v = abbe_pkg::CFG_DATA_W'(
                $urandom_range(1, (idx == abbe_pkg::REG_PARENT_WIDTH) ? 64 : 8));
        end else if (roll == 6) begin
          v = '0;
        end else if (roll == 7) begin
          v = abbe_pkg::CFG_DATA_W'(MAX_DIM);
        end else if (roll == 8) begin
          v = '1;
        end else begin
          v = abbe_pkg::CFG_DATA_W'($urandom());
        end
      end
      abbe_pkg::REG_PARENT_DEPTH, abbe_pkg::REG_OBJ_DEPTH: begin
        v = abbe_pkg::CFG_DATA_W'((roll < 7) ? $urandom_range(1, 4) : $urandom_range(0, 7));
      end
      abbe_pkg::REG_POS_X, abbe_pkg::REG_POS_Y: begin
        if (roll < 6) begin
          v = abbe_pkg::CFG_DATA_W'($urandom_range(0, 31));
        end else if (roll < 8) begin
          v = 12'hFFF;
        end else begin
          v = abbe_pkg::CFG_DATA_W'($urandom_range(0, 4095));
        end
      end
      default: begin
        v = abbe_pkg::CFG_DATA_W'($urandom_range(0, 1));
      end
    endcase
    return v;
  endfunction

  task automatic write_reg(input abbe_pkg::cfg_reg_e idx,
                           input logic [abbe_pkg::CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    case (idx)
      abbe_pkg::REG_PARENT_WIDTH: cfg_pw = val;
      abbe_pkg::REG_PARENT_DEPTH: cfg_pd = val[2:0];
      abbe_pkg::REG_POS_X:        cfg_px = val[11:0];
      abbe_pkg::REG_POS_Y:        cfg_py = val[11:0];
      abbe_pkg::REG_OBJ_WIDTH:    cfg_w = val;
      abbe_pkg::REG_OBJ_HEIGHT:   cfg_h = val;
      abbe_pkg::REG_OBJ_DEPTH:    cfg_od = val[2:0];
      default:                    cfg_mode = abbe_pkg::mode_e'(val[0]);
    endcase
  endtask

  task automatic close_writes();
    @(negedge clk);
    cfg_we <= 1'b0;
    n_setups++;
  endtask

  task automatic set_object(input logic [12:0] pw, input logic [2:0] pd, input logic [11:0] px,
                            input logic [11:0] py, input logic [12:0] w, input logic [12:0] h,
                            input logic [2:0] od, input abbe_pkg::mode_e mode);
    write_reg(abbe_pkg::REG_PARENT_WIDTH, pw);
    write_reg(abbe_pkg::REG_PARENT_DEPTH, abbe_pkg::CFG_DATA_W'(pd));
    write_reg(abbe_pkg::REG_POS_X, abbe_pkg::CFG_DATA_W'(px));
    write_reg(abbe_pkg::REG_POS_Y, abbe_pkg::CFG_DATA_W'(py));
    write_reg(abbe_pkg::REG_OBJ_WIDTH, w);
    write_reg(abbe_pkg::REG_OBJ_HEIGHT, h);
    write_reg(abbe_pkg::REG_OBJ_DEPTH, abbe_pkg::CFG_DATA_W'(od));
    write_reg(abbe_pkg::REG_BLEND_MODE, abbe_pkg::CFG_DATA_W'(mode));
    close_writes();
  endtask

  task automatic queue_pixel(input logic [abbe_pkg::SRC_W-1:0] src,
                             input logic [abbe_pkg::DEST_W-1:0] dest);
    pixel_pair_t p;
    p.src  = src;
    p.dest = dest;
    pixel_queue.push_back(p);
    queued++;
  endtask

  // block is idle once every queued item went in and every write came out
  task automatic drain();
    while (pixel_queue.size() != 0 || in_if.valid || expected_writes.size() != 0) begin
      @(posedge clk);
    end
  endtask

  // sender: bursts of items with random gaps between them
  always @(negedge clk) begin
    pixel_pair_t nxt;
    logic        show;
    show = in_if.valid && !in_taken;
    if (!show) begin
      if (gap_left != 0) begin
        gap_left--;
      end else if (pixel_queue.size() != 0) begin
        nxt = pixel_queue.pop_front();
        in_if.src_pixel  <= nxt.src;
        in_if.dest_pixel <= nxt.dest;
        show = 1'b1;
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 24);
          gap_left = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 8);
        end
      end
    end
    in_if.valid <= show;
  end

  // receiver: rotating stall mask, swapped now and then
  always @(negedge clk) begin
    if (pat_left == 0) begin
      pat_left = $urandom_range(32, 200);
      case ($urandom_range(3))
        0:       stall_pat = '1;
        1:       stall_pat = 16'(($urandom() & $urandom()) | 32'h1);
        default: stall_pat = 16'($urandom() | 32'h1);
      endcase
    end else begin
      pat_left--;
    end
    pat_pos = pat_pos + 1'b1;
    out_if.ready <= stall_pat[pat_pos];
  end

  always @(posedge clk) begin
    blit_write_t got, want;
    pixel_pair_t px;
    logic        bad;
    in_taken <= in_fire;
    if (out_fire) begin
      got.addr   = out_if.dest_addr;
      got.pixel  = out_if.out_pixel;
      got.nbytes = out_if.write_bytes;
      got.last   = out_if.last;
      got.err    = out_if.error;
      if (expected_writes.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
          $display("unexpected write: addr %h pixel %h bytes %0d last %b err %b",
                   got.addr, got.pixel, got.nbytes, got.last, got.err);
        end
      end else begin
        want = expected_writes.pop_front();
        n_errs += want.err;
        n_ends += want.last;
        bad = (got.addr !== want.addr) || (got.pixel !== want.pixel) ||
              (got.nbytes !== want.nbytes) || (got.last !== want.last) ||
              (got.err !== want.err);
        if (bad) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS) begin
            $display("write mismatch (exp/got): addr %h/%h pixel %h/%h bytes %0d/%0d",
                     want.addr, got.addr, want.pixel, got.pixel, want.nbytes, got.nbytes);
            $display("  last %b/%b err %b/%b", want.last, got.last, want.err, got.err);
          end
        end
      end
    end
    if (in_fire) begin
      px.src  = in_if.src_pixel;
      px.dest = in_if.dest_pixel;
      if (cfg_mode == abbe_pkg::MODE_ALPHA && cfg_od == abbe_pkg::DEPTH_MAX) n_blends++;
      expected_writes.push_back(predict_write(px));
      n_items++;
    end
  end

  // watchdog on cycles with no handshake at all
  always @(posedge clk) begin
    if (!rst_n || in_fire || out_fire || cfg_we) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("alpha_blend_blit_engine_top verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int unsigned                n, w, h, roll;
    logic [abbe_pkg::SRC_W-1:0] src;
    in_if.valid      = 1'b0;
    in_if.src_pixel  = '0;
    in_if.dest_pixel = '0;
    out_if.ready     = 1'b1;
    cfg_we   = 1'b0;
    cfg_idx  = abbe_pkg::REG_PARENT_WIDTH;
    cfg_data = '0;
    cfg_pw   = 13'd640;
    cfg_pd   = 3'd4;
    cfg_px   = '0;
    cfg_py   = '0;
    cfg_w    = 13'd1;
    cfg_h    = 13'd1;
    cfg_od   = 3'd4;
    cfg_mode = abbe_pkg::MODE_OPAQUE;
    col_cnt  = 0;
    row_cnt  = 0;
    rst_n    = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // reset configuration: one-pixel opaque object
    queue_pixel(32'h0000_0000, 24'h00_0000);
    queue_pixel(32'hFFFF_FFFF, 24'hFF_FFFF);
    drain();

    // saturated parent, object at the far corner so the address wraps
    set_object(13'h1FFF, 3'd7, 12'hFFF, 12'hFFF, 13'd2, 13'd2, abbe_pkg::DEPTH_MAX,
               abbe_pkg::MODE_ALPHA);
    queue_pixel(32'h00FF_FFFF, 24'h00_0000);
    queue_pixel(32'hFF00_0000, 24'hFF_FFFF);
    queue_pixel(32'hFFFF_FFFF, 24'h00_0000);
    queue_pixel(32'h8012_34FE, 24'h7F_80C1);
    drain();

    // alpha with a bad object depth reports an error and writes nothing
    write_reg(abbe_pkg::REG_OBJ_DEPTH, abbe_pkg::CFG_DATA_W'(3'd3));
    close_writes();
    queue_pixel(32'hFFFF_FFFF, 24'hFF_FFFF);
    queue_pixel(32'h1234_5678, 24'h9A_BCDE);
    drain();
    write_reg(abbe_pkg::REG_OBJ_DEPTH, abbe_pkg::CFG_DATA_W'(3'd0));
    close_writes();
    queue_pixel(32'hA5A5_A5A5, 24'h5A_5A5A);
    drain();

    // zero sizes and depths saturate up to one
    set_object(13'd0, 3'd0, 12'd0, 12'd0, 13'd0, 13'd3, 3'd0, abbe_pkg::MODE_OPAQUE);
    repeat (3) queue_pixel(32'hFFFF_FFFF, 24'hFF_FFFF);
    drain();

    set_object(13'd640, 3'd3, 12'd5, 12'd2, 13'd3, 13'd1, 3'd2, abbe_pkg::MODE_OPAQUE);
    repeat (3) queue_pixel($urandom(), abbe_pkg::DEST_W'($urandom()));
    drain();

    // shrink the object mid-scan so the column counter sits past the edge
    set_object(13'd16, 3'd4, 12'd1, 12'd1, 13'd8, 13'd8, 3'd7, abbe_pkg::MODE_OPAQUE);
    repeat (5) queue_pixel($urandom(), abbe_pkg::DEST_W'($urandom()));
    drain();
    write_reg(abbe_pkg::REG_OBJ_WIDTH, 13'd2);
    write_reg(abbe_pkg::REG_OBJ_HEIGHT, 13'd1);
    close_writes();
    repeat (3) queue_pixel($urandom(), abbe_pkg::DEST_W'($urandom()));
    drain();

    while (queued < TOTAL_ITEMS) begin
      for (int r = 0; r <= abbe_pkg::REG_BLEND_MODE; r++) begin
        if ($urandom_range(1) == 1) begin
          write_reg(abbe_pkg::cfg_reg_e'(r), pick_value(abbe_pkg::cfg_reg_e'(r)));
        end
      end
      // keep most alpha setups at a valid depth so blends dominate
      if (cfg_mode == abbe_pkg::MODE_ALPHA && cfg_od != abbe_pkg::DEPTH_MAX &&
          $urandom_range(3) != 0) begin
        write_reg(abbe_pkg::REG_OBJ_DEPTH, abbe_pkg::CFG_DATA_W'(abbe_pkg::DEPTH_MAX));
      end
      close_writes();
      w = fit_range(cfg_w, 1, MAX_DIM);
      h = fit_range(cfg_h, 1, MAX_DIM);
      if (w * h <= 64 && $urandom_range(1) == 1) begin
        n = w * h * $urandom_range(1, 4);
      end else begin
        n = $urandom_range(1, 60);
      end
      repeat (n) begin
        src = $urandom();
        roll = $urandom_range(7);
        if (roll == 0) src[31:24] = 8'h00;
        if (roll == 1) src[31:24] = 8'hFF;
        queue_pixel(src, abbe_pkg::DEST_W'($urandom()));
      end
      drain();
    end

    drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    mismatches += expected_writes.size();
    $display("%0d pixels over %0d register setups: %0d alpha blends, %0d depth errors",
             n_items, n_setups, n_blends, n_errs);
    $display("%0d object ends seen, %0d mismatches", n_ends, mismatches);
    if (mismatches == 0) begin
      $display("alpha_blend_blit_engine_top verification clean");
    end else begin
      $display("alpha_blend_blit_engine_top verification failed");
    end
    $finish;
  end

endmodule

### alpha_blend_blit_engine_top.f
hdl/abbe_pkg.sv
hdl/abbe_in_if.sv
hdl/abbe_out_if.sv
hdl/abbe_blend.sv
hdl/abbe_scan.sv
hdl/alpha_blend_blit_engine_top.sv
test/tb_alpha_blend_blit_engine_top.sv
